### rtl/core/raster_gradient_energy_unit_defines.svh
// Assertion helpers for the raster gradient energy unit.
// Set ASSERT_OFF to compile the checks away.
`ifndef RASTER_GRADIENT_ENERGY_UNIT_DEFINES_SVH
`define RASTER_GRADIENT_ENERGY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// ante holds at an edge -> cons holds at the same edge
`define RGE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rge: assertion failed");

// ante holds at an edge -> cons holds at the next edge
`define RGE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rge: assertion failed");

`else

`define RGE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RGE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/rge_pkg.sv
package rge_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CHAN_W        = 8;
  localparam int IMG_W_W       = 12;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = CFG_IDX_W'(1);

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = IMG_W_W'(640);

  // output queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // floor(d / 3) for 8-bit d: (d * 171) >> 9
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rge_pix_t;

  localparam int PIX_W = $bits(rge_pix_t);

  // per-item control handed from the column tracker to the datapath
  typedef struct packed {
    logic proc;      // item touches the line stores
    logic produce;   // item emits a result
    logic left_en;   // left neighbor inside the row
    logic right_en;  // right neighbor inside the row
    logic above_en;  // row above exists
  } rge_flags_t;

  typedef struct packed {
    logic [CHAN_W-1:0] grad_x;
    logic [CHAN_W-1:0] grad_y;
    logic [CHAN_W-1:0] grad_mean;
  } rge_res_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CHAN_W-1:0] div3(input logic [CHAN_W-1:0] d);
    logic [2*CHAN_W-1:0] p;
    p = (2*CHAN_W)'(d) * (2*CHAN_W)'(DIV3_MUL);
    return CHAN_W'(p >> DIV3_SHIFT);
  endfunction

  // grey: red channel only; color: sum of per-channel |diff| / 3 (max 255)
  function automatic logic [CHAN_W-1:0] gradient(input rge_pix_t a,
                                                 input rge_pix_t b,
                                                 input logic color);
    logic [CHAN_W-1:0] dr;
    logic [CHAN_W-1:0] dg;
    logic [CHAN_W-1:0] db;
    logic [CHAN_W+1:0] s;
    dr = abs_diff(a.red, b.red);
    dg = abs_diff(a.green, b.green);
    db = abs_diff(a.blue, b.blue);
    s  = (CHAN_W+2)'(div3(dr)) + (CHAN_W+2)'(div3(dg)) + (CHAN_W+2)'(div3(db));
    return color ? CHAN_W'(s) : dr;
  endfunction

endpackage

### rtl/core/rge_if.sv
interface rge_pix_if;
  import rge_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              frame_start;
  logic              flush;

  modport source (output valid, red, green, blue, frame_start, flush, input ready);
  modport sink   (input valid, red, green, blue, frame_start, flush, output ready);
endinterface

interface rge_grad_if;
  import rge_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] grad_x;
  logic [CHAN_W-1:0] grad_y;
  logic [CHAN_W-1:0] grad_mean;

  modport source (output valid, grad_x, grad_y, grad_mean, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_mean, output ready);
endinterface

interface rge_cfg_if;
  import rge_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/rge_ram.sv
module rge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rd_data_r;

endmodule

### rtl/core/rge_ctrl.sv
module rge_ctrl #(
  parameter int MAX_WIDTH = rge_pkg::MAX_WIDTH_DEF,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [rge_pkg::CHAN_W-1:0]   red,
  input  logic [rge_pkg::CHAN_W-1:0]   green,
  input  logic [rge_pkg::CHAN_W-1:0]   blue,
  input  logic                         frame_start,
  input  logic                         flush,
  input  logic [rge_pkg::IMG_W_W-1:0]  image_width,
  output rge_pkg::rge_flags_t          flags,
  output logic [AW-1:0]                x,
  output logic [AW-1:0]                x_nxt,
  output rge_pkg::rge_pix_t            px
);
  import rge_pkg::*;

  localparam int CW = (IMG_W_W > AW + 1) ? IMG_W_W : AW + 1;

  // row phase codes
  localparam logic [1:0] PH_FILL  = 2'd0;  // first row, no output
  localparam logic [1:0] PH_FIRST = 2'd1;  // emitting first row, above is zero
  localparam logic [1:0] PH_BODY  = 2'd2;  // emitting later rows

  logic [AW-1:0] col_r, col_nxt, col0;
  logic [1:0]    phase_r, phase_nxt, phase0, ph_adv;
  logic [CW-1:0] iw_w, eff, x_inc;
  logic          skip, last;

  always_comb begin
    iw_w = CW'(image_width);
    if (iw_w == '0) begin
      eff = CW'(1);
    end else if (iw_w > CW'(MAX_WIDTH)) begin
      eff = CW'(MAX_WIDTH);
    end else begin
      eff = iw_w;
    end

    phase0 = frame_start ? PH_FILL : phase_r;
    col0   = frame_start ? '0 : col_r;
    skip   = flush && (phase0 == PH_FILL);

    // width shrank mid-row: restart at column zero
    x     = (CW'(col0) >= eff) ? '0 : col0;
    x_inc = CW'(x) + CW'(1);
    last  = (x_inc >= eff);
    x_nxt = x_inc[AW-1:0];

    case (phase0)
      PH_FILL: ph_adv = PH_FIRST;
      default: ph_adv = PH_BODY;
    endcase

    flags.proc     = !skip;
    flags.produce  = (phase0 != PH_FILL);
    flags.left_en  = (x != '0);
    flags.right_en = !last;
    flags.above_en = (phase0 == PH_BODY);

    px = flush ? '0 : {red, green, blue};

    col_nxt   = col_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (skip) begin
        col_nxt   = col0;
        phase_nxt = phase0;
      end else if (last) begin
        col_nxt   = '0;
        phase_nxt = flush ? PH_FILL : ph_adv;
      end else begin
        col_nxt   = x_inc[AW-1:0];
        phase_nxt = phase0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      phase_r <= PH_FILL;
    end else begin
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

### rtl/core/rge_dp.sv
module rge_dp #(
  parameter int MAX_WIDTH = rge_pkg::MAX_WIDTH_DEF,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 issue_en,
  input  rge_pkg::rge_flags_t  flags,
  input  logic [AW-1:0]        x,
  input  logic [AW-1:0]        x_nxt,
  input  rge_pkg::rge_pix_t    px,
  input  logic                 color_mode,
  output logic                 res_push,
  output rge_pkg::rge_res_t    res,
  output logic                 s1_busy
);
  import rge_pkg::*;

  // store A: {upper, middle} at column x; store B: middle, read at x + 1
  logic [2*PIX_W-1:0] ram_a_rdata, wr_a_data, a_data, fwd_a_data_r;
  logic [PIX_W-1:0]   ram_b_rdata, b_data, fwd_b_data_r;

  logic          s1_valid_r, s1_valid_nxt;
  logic          fwd_a_r, fwd_a_nxt, fwd_b_r, fwd_b_nxt;
  rge_flags_t    s1_flags_r;
  logic [AW-1:0] s1_x_r;
  rge_pix_t      s1_px_r, prev_mid_r;
  rge_pix_t      upper_x, mid_old, lft, rgt, abv;
  logic [CHAN_W-1:0] gx, gy;
  logic [CHAN_W:0]   gsum;

  rge_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_ram_a (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata (wr_a_data),
    .re    (s1_valid_nxt),
    .raddr (x),
    .rdata (ram_a_rdata)
  );

  rge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_b (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata (s1_px_r),
    .re    (s1_valid_nxt),
    .raddr (x_nxt),
    .rdata (ram_b_rdata)
  );

  always_comb begin
    s1_valid_nxt = issue_en && flags.proc;
    // the stage-1 item writes at the same edge the new item reads: bypass
    fwd_a_nxt = s1_valid_nxt && s1_valid_r && (s1_x_r == x);
    fwd_b_nxt = s1_valid_nxt && s1_valid_r && flags.right_en && (s1_x_r == x_nxt);

    a_data  = fwd_a_r ? fwd_a_data_r : ram_a_rdata;
    b_data  = fwd_b_r ? fwd_b_data_r : ram_b_rdata;
    upper_x = a_data[2*PIX_W-1:PIX_W];
    mid_old = a_data[PIX_W-1:0];
    wr_a_data = {mid_old, s1_px_r};

    lft = s1_flags_r.left_en  ? prev_mid_r : '0;
    rgt = s1_flags_r.right_en ? rge_pix_t'(b_data) : '0;
    abv = s1_flags_r.above_en ? upper_x : '0;

    gx   = gradient(rgt, lft, color_mode);
    gy   = gradient(s1_px_r, abv, color_mode);
    gsum = {1'b0, gx} + {1'b0, gy};

    res.grad_x    = gx;
    res.grad_y    = gy;
    res.grad_mean = gsum[CHAN_W:1];
  end

  assign res_push = s1_valid_r && s1_flags_r.produce;
  assign s1_busy  = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_a_r    <= 1'b0;
      fwd_b_r    <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      fwd_a_r    <= fwd_a_nxt;
      fwd_b_r    <= fwd_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_en) begin
      s1_flags_r <= flags;
      s1_x_r     <= x;
      s1_px_r    <= px;
    end
    fwd_a_data_r <= wr_a_data;
    fwd_b_data_r <= s1_px_r;
    if (s1_valid_r) begin
      prev_mid_r <= mid_old;
    end
  end

endmodule

### rtl/core/rge_outq.sv
module rge_outq #(
  parameter int DEPTH = rge_pkg::OUTQ_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rge_pkg::rge_res_t push_data,
  input  logic              pop,
  output logic              q_valid,
  output rge_pkg::rge_res_t q_data,
  output logic [CNTW-1:0]   count
);
  import rge_pkg::*;

  rge_res_t        entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_pop;

  always_comb begin
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CNTW'(push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_data  = entry_r[rd_ptr_r];
  assign count   = count_r;

endmodule

### rtl/core/raster_gradient_energy_unit.sv
// Channel  Dir  Payload                                   Request taken when
// in_chan  in   red, green, blue, frame_start, flush      valid && ready
// out_chan out  grad_x, grad_y, grad_mean                 valid && ready
// cfg_chan in   reg_index (0 image_width, 1 color_mode),  valid && ready
//               wdata                                     (ready tied high)
//
// One pixel request per clock unless in_chan stalls. Each pixel needs a read of
// column x and x+1 and a write of column x in the line stores; two single-port-write
// memories serve that every cycle, so throughput is set by them at one request per cycle.
// A result is formed in stage 1 from the pixel one row below it and is queued.
// Reset (rst_n low, synchronous) clears control only; line stores need no
// clearing pass. in_chan stalls when the 3-entry result queue plus the pixel
// in flight would overflow; in steady flow one result already waits, so
// in_chan drops ready from the cycle after out_chan's first stalled cycle.
`include "raster_gradient_energy_unit_defines.svh"

module raster_gradient_energy_unit #(
  parameter int MAX_WIDTH = rge_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rge_pix_if.sink     in_chan,
  rge_grad_if.source  out_chan,
  rge_cfg_if.sink     cfg_chan
);
  import rge_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [IMG_W_W-1:0] image_width_r, image_width_nxt;
  logic               color_mode_r, color_mode_nxt;
  logic               cfg_accept;

  // request handshake and pipeline status
  logic                in_ready, in_accept;
  logic                s1_busy, res_push, q_valid, q_pop;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W:0]   inflight;

  rge_flags_t    iss_flags;
  logic [AW-1:0] iss_x, iss_x_nxt;
  rge_pix_t      iss_px;
  rge_res_t      res, q_data;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;
  assign cfg_accept     = cfg_chan.valid;

  always_comb begin
    image_width_nxt = image_width_r;
    color_mode_nxt  = color_mode_r;
    if (cfg_accept) begin
      case (cfg_chan.reg_index)
        REG_IMAGE_WIDTH: image_width_nxt = cfg_chan.wdata[IMG_W_W-1:0];
        REG_COLOR_MODE:  color_mode_nxt  = cfg_chan.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      color_mode_r  <= 1'b0;
    end else begin
      image_width_r <= image_width_nxt;
      color_mode_r  <= color_mode_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input handshake: take a pixel as long as the queue can hold everything
  // already accepted, counting the pixel sitting in stage 1.
  // ---------------------------------------------------------------------------
  assign inflight      = (OUTQ_CNT_W+1)'(q_count) + (OUTQ_CNT_W+1)'(s1_busy);
  assign in_ready      = (inflight < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;

  // Column / row tracking and neighbor-valid decode
  rge_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .red         (in_chan.red),
    .green       (in_chan.green),
    .blue        (in_chan.blue),
    .frame_start (in_chan.frame_start),
    .flush       (in_chan.flush),
    .image_width (image_width_r),
    .flags       (iss_flags),
    .x           (iss_x),
    .x_nxt       (iss_x_nxt),
    .px          (iss_px)
  );

  // Line stores, bypass and gradient arithmetic
  rge_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_en   (in_accept),
    .flags      (iss_flags),
    .x          (iss_x),
    .x_nxt      (iss_x_nxt),
    .px         (iss_px),
    .color_mode (color_mode_r),
    .res_push   (res_push),
    .res        (res),
    .s1_busy    (s1_busy)
  );

  // Result queue decouples the output side from the pixel stream
  assign q_pop = out_chan.ready;

  rge_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .count     (q_count)
  );

  assign out_chan.valid     = q_valid;
  assign out_chan.grad_x    = q_data.grad_x;
  assign out_chan.grad_y    = q_data.grad_y;
  assign out_chan.grad_mean = q_data.grad_mean;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `RGE_ASSERT_IMPL(a_no_queue_overflow, clk, rst_n, res_push && !(q_valid && q_pop), q_count < OUTQ_CNT_W'(OUTQ_DEPTH))
  `RGE_ASSERT_IMPL(a_result_from_pixel, clk, rst_n, res_push, $past(in_accept && iss_flags.proc))
  `RGE_ASSERT_IMPL(a_count_moves_on_traffic, clk, rst_n, !$stable(q_count), $past(res_push) != $past(q_valid && q_pop))

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rge_pkg::*;

  localparam int MAXW        = MAX_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 1800;

  // row state of the predictor
  typedef enum logic [1:0] {ROW_FILL, ROW_FIRST, ROW_LATER} row_phase_e;
  typedef enum logic {STEP_PIXEL, STEP_CFG} step_kind_e;

  typedef struct packed {
    rge_pix_t pix;
    logic     frame_start;
    logic     flush;
  } pixel_req_t;

  // One line of the directed table: either a register write or a pixel request.
  // When lit is set, the gradient triple is typed in and used as the expectation.
  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  fs;
    logic                  fl;
    logic                  lit;
    logic [7:0]            gx;
    logic [7:0]            gy;
    logic [7:0]            gm;
  } dir_row_t;

  localparam int DIR_ROWS = 35;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // grey mode, 3 pixels per row
    '{STEP_CFG,   REG_IMAGE_WIDTH, 12'd3, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_CFG,   REG_COLOR_MODE,  12'd0, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    // first row, no output; a flush in the middle of it is dropped
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd0,   8'd0,   1, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 0, 1, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd255, 8'd255, 0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd128, 8'd64,  0, 0, 0, 8'd0, 8'd0, 8'd0},
    // second row: results of the first row, nothing above
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd17,  8'd34,  0, 0, 1, 8'd0, 8'd255, 8'd127},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd90,  8'd200, 0, 0, 1, 8'd255, 8'd0, 8'd127},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd200, 8'd5,   8'd250, 0, 0, 1, 8'd0, 8'd200, 8'd100},
    // third row: full neighborhood
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   0, 0, 1, 8'd0, 8'd255, 8'd127},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd77,  8'd1,   8'd254, 0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd128, 8'd255, 8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    // flush row drains the last row, pixel bytes are don't-care
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 0, 1, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   0, 1, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd0,   8'd255, 0, 1, 0, 8'd0, 8'd0, 8'd0},
    // color mode, 2 pixels per row
    '{STEP_CFG,   REG_COLOR_MODE,  12'd1, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_CFG,   REG_IMAGE_WIDTH, 12'd2, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   0, 0, 1, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 0, 0, 1, 8'd255, 8'd255, 8'd255},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd30,  8'd60,  8'd90,  0, 0, 0, 8'd0, 8'd0, 8'd0},
    // width 0 clamps to 1 while the column sits at 1: column wraps to 0
    '{STEP_CFG,   REG_IMAGE_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd100, 8'd150, 8'd200, 0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd9,   8'd8,   8'd7,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    // wider again, so a new frame starts; restart in the middle of its first row
    '{STEP_CFG,   REG_IMAGE_WIDTH, 12'd3, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_CFG,   REG_COLOR_MODE,  12'd0, 8'd0,   8'd0,   8'd0,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd12,  8'd34,  8'd56,  1, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd250, 8'd3,   8'd3,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd1,   8'd2,   8'd3,   1, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd4,   8'd5,   8'd6,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd7,   8'd8,   8'd9,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd60,  8'd70,  8'd80,  0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd1,   8'd1,   8'd1,   0, 0, 0, 8'd0, 8'd0, 8'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 12'd0, 8'd254, 8'd254, 8'd254, 0, 0, 0, 8'd0, 8'd0, 8'd0}
  };

  logic clk;
  logic rst_n;

  rge_pix_if  pix_bus();
  rge_grad_if grad_bus();
  rge_cfg_if  cfg_bus();

  raster_gradient_energy_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_bus),
    .out_chan (grad_bus),
    .cfg_chan (cfg_bus)
  );

  // predictor state: line stores, column, row phase, left neighbor, registers
  rge_pix_t           upper_mem [MAXW];
  rge_pix_t           middle_mem [MAXW];
  int unsigned        col_idx   = 0;
  row_phase_e         phase     = ROW_FILL;
  rge_pix_t           left_hold = '0;
  logic [IMG_W_W-1:0] width_reg = IMAGE_WIDTH_RST;
  logic               color_reg = 1'b0;

  rge_res_t grad_due [$];   // predicted gradients, oldest first

  int unsigned cycles        = 0;
  int unsigned fails         = 0;
  int unsigned px_used       = 0;
  int unsigned px_ignored    = 0;
  int unsigned grads_checked = 0;
  int unsigned cfg_writes    = 0;
  bit          steady        = 1'b0;  // no idling on either side while set
  int unsigned hold_requests = 0;     // long receiver hold-offs asked for
  int unsigned holds_done    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic int unsigned eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAXW) return MAXW;
    return int'(width_reg);
  endfunction

  // |a - b| on red in grey mode; sum of per-channel |a - b| / 3 in color mode
  function automatic logic [7:0] pair_grad(input rge_pix_t a, input rge_pix_t b);
    int dr;
    int dg;
    int db;
    dr = int'(a.red) - int'(b.red);
    dg = int'(a.green) - int'(b.green);
    db = int'(a.blue) - int'(b.blue);
    if (dr < 0) dr = -dr;
    if (dg < 0) dg = -dg;
    if (db < 0) db = -db;
    if (!color_reg) return 8'(dr);
    return 8'(dr / 3 + dg / 3 + db / 3);
  endfunction

  // Advance the line-store predictor by one accepted pixel request.
  // used: request was not dropped; made: a gradient result is due.
  function automatic void predict_gradient(input pixel_req_t rq, output bit used,
                                           output bit made, output rge_res_t res);
    int unsigned eff;
    int unsigned x;
    rge_pix_t    px;
    rge_pix_t    mid_old;
    rge_pix_t    left_px;
    rge_pix_t    right_px;
    rge_pix_t    above_px;
    used = 1'b0;
    made = 1'b0;
    res  = '0;
    eff  = eff_width();
    if (rq.frame_start) begin
      col_idx   = 0;
      phase     = ROW_FILL;
      left_hold = '0;
    end
    // flush while the first row is still filling: dropped
    if (rq.flush && phase == ROW_FILL) return;
    used = 1'b1;
    // width shrank under the current column
    if (col_idx >= eff) begin
      col_idx   = 0;
      left_hold = '0;
    end
    px      = rq.flush ? '0 : rq.pix;
    x       = col_idx;
    mid_old = middle_mem[x];
    if (phase != ROW_FILL) begin
      left_px  = (x > 0) ? left_hold : '0;
      right_px = (x + 1 < eff) ? middle_mem[x + 1] : '0;
      above_px = (phase == ROW_LATER) ? upper_mem[x] : '0;
      res.grad_x    = pair_grad(right_px, left_px);
      res.grad_y    = pair_grad(px, above_px);
      res.grad_mean = 8'((9'(res.grad_x) + 9'(res.grad_y)) >> 1);
      made = 1'b1;
    end
    upper_mem[x]  = mid_old;
    middle_mem[x] = px;
    left_hold     = mid_old;
    if (x + 1 >= eff) begin
      col_idx   = 0;
      left_hold = '0;
      if (rq.flush) phase = ROW_FILL;
      else phase = (phase == ROW_FILL) ? ROW_FIRST : ROW_LATER;
    end else begin
      col_idx = x + 1;
    end
  endfunction

  // Output checker: each result is matched against the oldest prediction.
  always @(posedge clk) begin : grad_check
    rge_res_t want;
    if (rst_n && grad_bus.valid && grad_bus.ready) begin
      if (grad_due.size() == 0) begin
        $error("unexpected result: grad_x %0d grad_y %0d grad_mean %0d",
               grad_bus.grad_x, grad_bus.grad_y, grad_bus.grad_mean);
        fails++;
      end else begin
        want = grad_due.pop_front();
        grads_checked++;
        if (grad_bus.grad_x !== want.grad_x) begin
          $error("grad_x: expected %0d, actual %0d", want.grad_x, grad_bus.grad_x);
          fails++;
        end
        if (grad_bus.grad_y !== want.grad_y) begin
          $error("grad_y: expected %0d, actual %0d", want.grad_y, grad_bus.grad_y);
          fails++;
        end
        if (grad_bus.grad_mean !== want.grad_mean) begin
          $error("grad_mean: expected %0d, actual %0d", want.grad_mean, grad_bus.grad_mean);
          fails++;
        end
      end
    end
  end

  // Result receiver: random back-pressure, none while steady, plus long
  // hold-offs that let the result queue fill and stall in_chan.
  initial begin : grad_sink
    grad_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        grad_bus.ready <= 1'b0;
        repeat (79) @(negedge clk);
        holds_done++;
      end else if (steady) begin
        grad_bus.ready <= 1'b1;
      end else begin
        grad_bus.ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // Offer one pixel request; entered and left at a falling edge. The
  // prediction is taken at the accepting edge.
  task automatic send_pixel(input pixel_req_t rq, input bit use_lit = 1'b0,
                            input rge_res_t lit = '0);
    bit       used;
    bit       made;
    rge_res_t res;
    while (!steady && $urandom_range(99) < 9) begin
      pix_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.red         <= rq.pix.red;
    pix_bus.green       <= rq.pix.green;
    pix_bus.blue        <= rq.pix.blue;
    pix_bus.frame_start <= rq.frame_start;
    pix_bus.flush       <= rq.flush;
    do @(posedge clk); while (!pix_bus.ready);
    predict_gradient(rq, used, made, res);
    if (used) px_used++;
    else px_ignored++;
    if (made) grad_due.push_back(use_lit ? lit : res);
    @(negedge clk);
  endtask

  // Register write request; the predictor copy changes at the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_IMAGE_WIDTH: width_reg = val;
      REG_COLOR_MODE:  color_reg = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain: stop offering, wait for every due result, then idle with no pixel
  // offered so the pipe clears.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    while (grad_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stim
    dir_row_t           row;
    pixel_req_t         rq;
    rge_res_t           lit;
    int unsigned        eff;
    int unsigned        n;
    int unsigned        roll;
    int unsigned        rand_from;
    int unsigned        idx;
    logic [IMG_W_W-1:0] wnext;

    rst_n               = 1'b0;
    pix_bus.valid       = 1'b0;
    pix_bus.red         = '0;
    pix_bus.green       = '0;
    pix_bus.blue        = '0;
    pix_bus.frame_start = 1'b0;
    pix_bus.flush       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_index   = REG_IMAGE_WIDTH;
    cfg_bus.wdata       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == STEP_CFG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        rq.pix.red      = row.red;
        rq.pix.green    = row.green;
        rq.pix.blue     = row.blue;
        rq.frame_start  = row.fs;
        rq.flush        = row.fl;
        lit.grad_x      = row.gx;
        lit.grad_y      = row.gy;
        lit.grad_mean   = row.gm;
        send_pixel(rq, row.lit, lit);
      end
    end

    // Random frames: mostly well-formed rows behind a frame start, often
    // closed by a flush row; stray flushes, restarts and shrinks mixed in.
    // The width only grows in front of a frame start, so no line-store
    // entry is read before it has been written.
    rand_from = px_used;
    while (px_used - rand_from < RAND_ITEMS) begin
      if ($urandom_range(2) == 0) begin
        settle();
        roll = $urandom_range(99);
        if (roll < 5) wnext = '0;
        else if (roll < 10) wnext = IMG_W_W'(1);
        else if (roll < 15) wnext = IMG_W_W'(2);
        else if (roll < 85) wnext = IMG_W_W'($urandom_range(3, 12));
        else wnext = IMG_W_W'($urandom_range(13, 40));
        write_reg(REG_IMAGE_WIDTH, wnext);
        write_reg(REG_COLOR_MODE, CFG_DATA_W'($urandom_range(1)));
      end
      eff = eff_width();
      n   = eff * $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        rq.pix         = 24'($urandom);
        rq.frame_start = (k == 0);
        rq.flush       = 1'b0;
        roll = $urandom_range(999);
        if (roll < 15) begin
          rq.flush = 1'b1;
        end else if (roll < 22) begin
          rq.frame_start = 1'b1;
        end else if (roll < 28) begin
          // shrink or recolor mid-row once idle
          settle();
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, eff_width())));
          if ($urandom_range(1) == 0)
            write_reg(REG_COLOR_MODE, CFG_DATA_W'($urandom_range(1)));
        end
        send_pixel(rq);
        idx    = px_used - rand_from;
        steady = (idx >= 400 && idx < 800);
        if (idx >= 1000 && hold_requests == 0) hold_requests = 1;
        if (idx >= 1400 && hold_requests == 1) hold_requests = 2;
      end
      if ($urandom_range(3) != 0) begin
        for (int k = 0; k < eff_width(); k++) begin
          rq.pix         = 24'($urandom);
          rq.frame_start = 1'b0;
          rq.flush       = 1'b1;
          send_pixel(rq);
        end
      end
    end

    settle();
    repeat (12) @(negedge clk);
    $display("covered %0d pixel requests (%0d dropped flushes), %0d results checked",
             px_used, px_ignored, grads_checked);
    $display("%0d register writes: widths 0 to 40, grey and color modes", cfg_writes);
    if (fails == 0 && grad_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rge_pkg.sv
rtl/core/rge_if.sv
rtl/core/rge_ram.sv
rtl/core/rge_ctrl.sv
rtl/core/rge_dp.sv
rtl/core/rge_outq.sv
rtl/core/raster_gradient_energy_unit.sv
dv/tb_top.sv
